[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER_CLK(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER_CLK(lbl, clk, rstn, expr, msg)
`endif
`endif

[hdl/srle_pkg.sv]
// ---------------------------------------------------------------------------
// Subpicture RLE package
// Shared types, constants and the run coding function.
// ---------------------------------------------------------------------------
package srle_pkg;

	localparam logic [7:0] RUN_MAX      = 8'd255;
	localparam logic [7:0] LEN_ONE_MAX  = 8'd3;
	localparam logic [7:0] LEN_TWO_MAX  = 8'd15;
	localparam logic [7:0] LEN_THREE_MAX = 8'd63;
	localparam logic [3:0] ZERO_NIBBLE  = 4'h0;
	localparam logic       REG_EOL_ENABLE = 1'b0;

	typedef logic [3:0] nibble_t;

	typedef struct packed {
		nibble_t [3:0] nib;
		logic [2:0]    cnt;
	} code_t;

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;
		logic            row_done;
	} entry_t;

	typedef struct packed {
		logic run_empty;
		logic nibble_waiting;
	} front_status_t;

	function automatic code_t run_code(input logic [1:0] color, input logic [7:0] n);
		code_t   c;
		nibble_t tail;
		c = '0;
		tail = {n[1:0], color};
		if (n > LEN_THREE_MAX) begin
			c.nib[0] = ZERO_NIBBLE;
			c.nib[1] = {2'b00, n[7:6]};
			c.nib[2] = n[5:2];
			c.nib[3] = tail;
			c.cnt = 3'd4;
		end else if (n > LEN_TWO_MAX) begin
			c.nib[0] = ZERO_NIBBLE;
			c.nib[1] = n[5:2];
			c.nib[2] = tail;
			c.cnt = 3'd3;
		end else if (n > LEN_ONE_MAX) begin
			c.nib[0] = n[5:2];
			c.nib[1] = tail;
			c.cnt = 3'd2;
		end else begin
			c.nib[0] = tail;
			c.cnt = 3'd1;
		end
		return c;
	endfunction

endpackage

[hdl/srle_front.sv]
// ---------------------------------------------------------------------------
// Subpicture RLE front end
// Tracks the open run and packs the nibbles an accepted pixel causes into
// a queue entry of up to three bytes.
// ---------------------------------------------------------------------------
module srle_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    eol_enable,
	input  logic                    accept,
	input  logic [1:0]              pixel,
	input  logic                    row_end,
	output logic                    push,
	output srle_pkg::entry_t        entry,
	output srle_pkg::front_status_t status
);
	import srle_pkg::*;

	logic [1:0] run_color_q;
	logic [7:0] run_length_q;
	nibble_t    held_nibble_q;
	logic       nibble_waiting_q;

	logic       close_run;
	logic [1:0] cur_color;
	logic [7:0] cur_len;
	code_t      seg [3];
	nibble_t    nib_buf [8];
	logic [3:0] k;
	logic [3:0] k_mid;
	logic       use_eol;

	always_comb begin
		close_run = (run_length_q != 8'd0) &&
			((pixel != run_color_q) || (run_length_q == RUN_MAX));
		if ((run_length_q == 8'd0) || close_run) begin
			cur_color = pixel;
			cur_len = 8'd1;
		end else begin
			cur_color = run_color_q;
			cur_len = run_length_q + 8'd1;
		end
		use_eol = eol_enable && (cur_color == 2'd0) && (cur_len > LEN_THREE_MAX);

		seg[0] = '0;
		seg[0].nib[0] = held_nibble_q;
		seg[0].cnt = {2'b00, nibble_waiting_q};
		seg[1] = close_run ? run_code(run_color_q, run_length_q) : '0;
		if (!row_end) begin
			seg[2] = '0;
		end else if (use_eol) begin
			seg[2] = '0;
			seg[2].cnt = 3'd4;
		end else begin
			seg[2] = run_code(cur_color, cur_len);
		end

		for (int b = 0; b < 8; b++) begin
			nib_buf[b] = ZERO_NIBBLE;
		end
		k = 4'd0;
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < seg[j].cnt) begin
					nib_buf[3'(k + 4'(i))] = seg[j].nib[i];
				end
			end
			k = k + {1'b0, seg[j].cnt};
		end
		k_mid = k;
		if (row_end && k_mid[0]) begin
			k = k + 4'd1;
		end

		entry.bytes[0] = {nib_buf[0], nib_buf[1]};
		entry.bytes[1] = {nib_buf[2], nib_buf[3]};
		entry.bytes[2] = {nib_buf[4], nib_buf[5]};
		entry.count = k[2:1];
		entry.row_done = row_end;
		push = accept && (k[3:1] != 3'd0);

		status.run_empty = (run_length_q == 8'd0);
		status.nibble_waiting = nibble_waiting_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_color_q <= 2'd0;
			run_length_q <= 8'd0;
			held_nibble_q <= ZERO_NIBBLE;
			nibble_waiting_q <= 1'b0;
		end else if (accept) begin
			if (row_end) begin
				run_color_q <= 2'd0;
				run_length_q <= 8'd0;
				held_nibble_q <= ZERO_NIBBLE;
				nibble_waiting_q <= 1'b0;
			end else begin
				run_color_q <= cur_color;
				run_length_q <= cur_len;
				held_nibble_q <= k[0] ? nib_buf[3'(k - 4'd1)] : ZERO_NIBBLE;
				nibble_waiting_q <= k[0];
			end
		end
	end

endmodule

[hdl/srle_queue.sv]
// ---------------------------------------------------------------------------
// Subpicture RLE entry queue
// Small register FIFO of byte groups between the front and back ends.
// ---------------------------------------------------------------------------
module srle_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  srle_pkg::entry_t push_entry,
	input  logic             pop,
	output srle_pkg::entry_t head,
	output logic             full,
	output logic             empty
);
	import srle_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t             entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[hdl/srle_back.sv]
// ---------------------------------------------------------------------------
// Subpicture RLE back end
// Serializes the bytes of the queue head onto the output stream.
// ---------------------------------------------------------------------------
module srle_back (
	input  logic             clk,
	input  logic             arst_n,
	input  srle_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);
	import srle_pkg::*;

	logic [1:0] idx_q;
	logic       last_byte;

	assign last_byte = (idx_q == (head.count - 2'd1));
	assign m_tvalid = !empty;
	assign m_tdata = head.bytes[idx_q];
	assign m_tlast = head.row_done && last_byte;
	assign pop = m_tvalid && m_tready && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			idx_q <= last_byte ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

[hdl/subpicture_rle_row_encoder.sv]
// ---------------------------------------------------------------------------
// Subpicture RLE row encoder
// Run-length codes two-bit pixels into the nibble-packed subpicture byte stream.
// ---------------------------------------------------------------------------
// The block accepts one pixel per cycle whenever its entry queue has room.
// A pixel yields zero to three bytes, which are written as one queue entry
// in the cycle the pixel is accepted; the output side drains one byte per
// cycle from the queue head while m_tready is high, so the sustained input
// rate then stays at one pixel per cycle while the coded stream averages at
// most one byte per cycle. tlast on the output marks the final byte of a
// row, including end-of-line and padding bytes.
`include "assert_macros.svh"

module subpicture_rle_row_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: [1:0] pixel, [7:2] zero. s_tlast: row_end.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	// m_tdata: [7:0] out_byte. m_tlast: row_done.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import srle_pkg::*;

	logic          eol_enable_q;
	logic          accept;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;
	entry_t        entry;
	entry_t        head;
	front_status_t front_status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EOL_ENABLE) ? {31'd0, eol_enable_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eol_enable_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_EOL_ENABLE)) begin
			eol_enable_q <= pwdata[0];
		end
	end

	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;

	srle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.eol_enable (eol_enable_q),
		.accept     (accept),
		.pixel      (s_tdata[1:0]),
		.row_end    (s_tlast),
		.push       (push),
		.entry      (entry),
		.status     (front_status)
	);

	srle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	srle_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`ASSERT_NEVER_CLK(a_push_when_full, clk, arst_n, push && q_full, "entry pushed into a full queue")
	`ASSERT_CLK(a_row_end_pushes, clk, arst_n, (accept && s_tlast) |-> (push && entry.row_done), "row end produced no bytes")
	`ASSERT_CLK(a_row_end_clears, clk, arst_n, (accept && s_tlast) |=> (front_status.run_empty && !front_status.nibble_waiting), "run state not cleared after row end")

endmodule
